// ----- hdl/tmcl_pkg.sv -----
package tmcl_pkg;

    localparam int unsigned MAX_DIM = 16384;

    localparam logic [3:0] FMT_R8        = 4'd0;
    localparam logic [3:0] FMT_RGBA8     = 4'd1;
    localparam logic [3:0] FMT_RGBA8_SRGB = 4'd2;
    localparam logic [3:0] FMT_BC1       = 4'd3;
    localparam logic [3:0] FMT_BC1_SRGB  = 4'd4;
    localparam logic [3:0] FMT_BC4       = 4'd5;
    localparam logic [3:0] FMT_BC3       = 4'd6;
    localparam logic [3:0] FMT_BC3_SRGB  = 4'd7;
    localparam logic [3:0] FMT_BC5       = 4'd8;
    localparam logic [3:0] FMT_BC7       = 4'd9;
    localparam logic [3:0] FMT_BC7_SRGB  = 4'd10;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_DIM = 2'd1;
    localparam logic [1:0] ST_BAD_FMT = 2'd2;

    typedef struct packed {
        logic [3:0]  format;
        logic [14:0] width;
        logic [14:0] height;
        logic [3:0]  num_levels;
    } t_req;

    typedef struct packed {
        logic [3:0]  level;
        logic [14:0] lvl_width;
        logic [14:0] lvl_height;
        logic [30:0] lvl_offset;
        logic [30:0] lvl_bytes;
        logic [30:0] total_bytes;
        logic [1:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       blocked;
        logic [2:0] shift;
    } t_size_ctrl;

    typedef struct packed {
        logic       supported;
        t_size_ctrl size;
        logic [3:0] align_mask;
    } t_fmt_info;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN
    } t_state;

    function automatic t_fmt_info fmt_decode(input logic [3:0] fmt);
        t_fmt_info info;
        info = '0;
        unique case (fmt)
            FMT_R8: begin
                info.supported  = 1'b1;
                info.size.shift = 3'd0;
                info.align_mask = 4'd3;
            end
            FMT_RGBA8, FMT_RGBA8_SRGB: begin
                info.supported  = 1'b1;
                info.size.shift = 3'd2;
                info.align_mask = 4'd3;
            end
            FMT_BC1, FMT_BC1_SRGB, FMT_BC4: begin
                info.supported    = 1'b1;
                info.size.blocked = 1'b1;
                info.size.shift   = 3'd3;
                info.align_mask   = 4'd7;
            end
            FMT_BC3, FMT_BC3_SRGB, FMT_BC5, FMT_BC7, FMT_BC7_SRGB: begin
                info.supported    = 1'b1;
                info.size.blocked = 1'b1;
                info.size.shift   = 3'd4;
                info.align_mask   = 4'd15;
            end
            default: begin
                info = '0;
            end
        endcase
        return info;
    endfunction

endpackage

// ----- hdl/texture_mip_chain_layout.sv -----
// channel   | ports                | transfer when
// ----------+----------------------+-------------------------------
// request   | start, busy, i_req   | start high and busy low at clock edge
// result    | o_strobe, o_result   | o_strobe high, one cycle per result
//
// the check state after the request transfer, then one result per cycle
// per mip level from the shared multiply and shift unit
// busy from the cycle after the transfer until the last result is shown
// error requests give one result after the check cycle
// reset clears the sequencer and the strobe; the receiver cannot stall
module texture_mip_chain_layout
    import tmcl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    t_state      r_state;
    t_state      n_state;
    t_req        r_req;
    t_fmt_info   r_fmt;
    t_fmt_info   n_fmt;
    logic [14:0] r_w;
    logic [14:0] n_w;
    logic [14:0] r_h;
    logic [14:0] n_h;
    logic [3:0]  r_lvl;
    logic [3:0]  n_lvl;
    logic [30:0] r_total;
    logic [30:0] n_total;
    logic        r_strobe;
    logic        n_strobe;
    t_result     r_out;
    t_result     n_out;

    logic        size_load;
    logic [14:0] size_w;
    logic [14:0] size_h;
    logic [30:0] unit_bytes;

    logic [14:0] dim_max;
    logic [14:0] dim_top;
    logic        dim_bad;
    logic [31:0] off_sum;
    logic [30:0] off_aligned;
    logic [30:0] level_off;
    logic        is_last;

    tmcl_size_unit u_size (
        .i_clk    (i_clk),
        .i_load   (size_load),
        .i_width  (size_w),
        .i_height (size_h),
        .i_ctrl   (r_fmt.size),
        .o_bytes  (unit_bytes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && r_state == S_IDLE) begin
            r_req <= i_req;
        end
        r_fmt   <= n_fmt;
        r_w     <= n_w;
        r_h     <= n_h;
        r_lvl   <= n_lvl;
        r_total <= n_total;
        r_out   <= n_out;
    end

    always_comb begin
        dim_max = (r_req.width > r_req.height) ? r_req.width : r_req.height;
        dim_top = dim_max >> (r_req.num_levels - 4'd1);
        dim_bad = (r_req.width == '0) || (r_req.height == '0) ||
                  ({17'd0, r_req.width} > 32'(MAX_DIM)) ||
                  ({17'd0, r_req.height} > 32'(MAX_DIM)) ||
                  (r_req.num_levels == '0) || (dim_top == '0);

        off_sum     = {1'b0, r_total} + {28'd0, r_fmt.align_mask};
        off_aligned = off_sum[30:0] & ~{27'd0, r_fmt.align_mask};
        level_off   = (r_lvl == '0) ? r_total : off_aligned;
        is_last     = (r_lvl == r_req.num_levels - 4'd1);

        n_state   = r_state;
        n_fmt     = r_fmt;
        n_w       = r_w;
        n_h       = r_h;
        n_lvl     = r_lvl;
        n_total   = r_total;
        n_strobe  = 1'b0;
        n_out     = r_out;
        size_load = 1'b0;
        size_w    = r_req.width;
        size_h    = r_req.height;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                    n_fmt   = fmt_decode(i_req.format);
                end
            end
            S_CHECK: begin
                if (dim_bad || !r_fmt.supported) begin
                    n_strobe     = 1'b1;
                    n_out        = '0;
                    n_out.status = dim_bad ? ST_BAD_DIM : ST_BAD_FMT;
                    n_out.last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    size_load = 1'b1;
                    n_w       = r_req.width;
                    n_h       = r_req.height;
                    n_lvl     = '0;
                    n_total   = '0;
                    n_state   = S_RUN;
                end
            end
            S_RUN: begin
                n_strobe          = 1'b1;
                n_out.level       = r_lvl;
                n_out.lvl_width   = r_w;
                n_out.lvl_height  = r_h;
                n_out.lvl_offset  = level_off;
                n_out.lvl_bytes   = unit_bytes;
                n_out.total_bytes = level_off + unit_bytes;
                n_out.status      = ST_OK;
                n_out.last        = is_last;
                n_total           = level_off + unit_bytes;
                n_lvl             = r_lvl + 4'd1;
                n_w               = (r_w[14:1] == '0) ? 15'd1 : {1'b0, r_w[14:1]};
                n_h               = (r_h[14:1] == '0) ? 15'd1 : {1'b0, r_h[14:1]};
                size_load         = 1'b1;
                size_w            = n_w;
                size_h            = n_h;
                if (is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ----- hdl/tmcl_size_unit.sv -----
module tmcl_size_unit
    import tmcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_load,
    input  logic [14:0] i_width,
    input  logic [14:0] i_height,
    input  t_size_ctrl  i_ctrl,
    output logic [30:0] o_bytes
);

    logic [30:0] r_bytes;
    logic [30:0] n_bytes;
    logic [15:0] w_round;
    logic [15:0] h_round;
    logic [14:0] op_a;
    logic [14:0] op_b;
    logic [29:0] prod;

    always_comb begin
        w_round = {1'b0, i_width} + 16'd3;
        h_round = {1'b0, i_height} + 16'd3;
        if (i_ctrl.blocked) begin
            op_a = {1'b0, w_round[15:2]};
            op_b = {1'b0, h_round[15:2]};
        end else begin
            op_a = i_width;
            op_b = i_height;
        end
        prod    = op_a * op_b;
        n_bytes = {1'b0, prod} << i_ctrl.shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= n_bytes;
        end
    end

    assign o_bytes = r_bytes;

endmodule

// ----- bench/texture_mip_chain_layout_tb.sv -----
module texture_mip_chain_layout_tb;
    import tmcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned ITEMS_PER_PHASE = 112;
    localparam int unsigned DIRECTED_ROWS  = 23;

    typedef struct packed {
        t_req    req;
        logic    typed;
        t_result want;
    } t_stim_row;

    localparam t_result RES_NONE = '0;
    localparam t_result RES_1X1  = '{4'd0, 15'd1, 15'd1, 31'd0, 31'd1, 31'd1, ST_OK, 1'b1};
    localparam t_result RES_DIM  = '{4'd0, 15'd0, 15'd0, 31'd0, 31'd0, 31'd0, ST_BAD_DIM, 1'b1};
    localparam t_result RES_FMT  = '{4'd0, 15'd0, 15'd0, 31'd0, 31'd0, 31'd0, ST_BAD_FMT, 1'b1};

    localparam t_stim_row STIM_TABLE [DIRECTED_ROWS] = '{
        '{'{FMT_R8,         15'd1,     15'd1,     4'd1},  1'b1, RES_1X1},
        '{'{FMT_RGBA8,      15'd0,     15'd16,    4'd1},  1'b1, RES_DIM},
        '{'{FMT_RGBA8,      15'd16,    15'd0,     4'd1},  1'b1, RES_DIM},
        '{'{FMT_BC1,        15'd16385, 15'd1,     4'd1},  1'b1, RES_DIM},
        '{'{FMT_BC1,        15'd1,     15'd16385, 4'd1},  1'b1, RES_DIM},
        '{'{FMT_BC7,        15'd32767, 15'd32767, 4'd15}, 1'b1, RES_DIM},
        '{'{FMT_R8,         15'd64,    15'd64,    4'd0},  1'b1, RES_DIM},
        '{'{FMT_BC3,        15'd16,    15'd16,    4'd6},  1'b1, RES_DIM},
        '{'{FMT_R8,         15'd1,     15'd1,     4'd15}, 1'b1, RES_DIM},
        '{'{4'd11,          15'd16,    15'd16,    4'd1},  1'b1, RES_FMT},
        '{'{4'd15,          15'd16384, 15'd16384, 4'd15}, 1'b1, RES_FMT},
        '{'{4'd15,          15'd0,     15'd16384, 4'd1},  1'b1, RES_DIM},
        '{'{FMT_R8,         15'd16384, 15'd16384, 4'd15}, 1'b0, RES_NONE},
        '{'{FMT_RGBA8,      15'd16384, 15'd16384, 4'd15}, 1'b0, RES_NONE},
        '{'{FMT_RGBA8_SRGB, 15'd1,     15'd16384, 4'd15}, 1'b0, RES_NONE},
        '{'{FMT_BC1,        15'd16384, 15'd1,     4'd15}, 1'b0, RES_NONE},
        '{'{FMT_BC1_SRGB,   15'd5,     15'd3,     4'd3},  1'b0, RES_NONE},
        '{'{FMT_BC4,        15'd7,     15'd13,    4'd4},  1'b0, RES_NONE},
        '{'{FMT_BC3,        15'd16384, 15'd16384, 4'd15}, 1'b0, RES_NONE},
        '{'{FMT_BC3_SRGB,   15'd9,     15'd1,     4'd4},  1'b0, RES_NONE},
        '{'{FMT_BC5,        15'd3,     15'd3,     4'd2},  1'b0, RES_NONE},
        '{'{FMT_BC7,        15'd16384, 15'd16384, 4'd15}, 1'b0, RES_NONE},
        '{'{FMT_BC7_SRGB,   15'd13,    15'd7,     4'd1},  1'b0, RES_NONE}
    };

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_req    i_req = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    t_result     pending_levels[$];
    int unsigned failures = 0;
    int unsigned requests_sent = 0;
    int unsigned levels_checked = 0;
    int unsigned errors_checked = 0;
    int unsigned stuck_cycles = 0;

    texture_mip_chain_layout dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned chain_len(input longint unsigned w, input longint unsigned h);
        longint unsigned span;
        int unsigned n;
        span = (w > h) ? w : h;
        n = 0;
        while (span != 0) begin
            n++;
            span = span >> 1;
        end
        return n;
    endfunction

    function automatic logic [30:0] sat31(input longint unsigned v);
        return (v > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : v[30:0];
    endfunction

    task automatic expect_result(input t_result r);
        pending_levels = {pending_levels, r};
    endtask

    task automatic predict_layout(input t_req req);
        longint unsigned w, h, unit, align, running, off, size;
        logic blocked;
        t_result r;
        w = req.width;
        h = req.height;
        r = '0;
        r.last = 1'b1;
        if (w == 0 || h == 0 || w > MAX_DIM || h > MAX_DIM || req.num_levels == 0 ||
            req.num_levels > chain_len(w, h)) begin
            r.status = ST_BAD_DIM;
            expect_result(r);
            return;
        end
        blocked = 1'b0;
        unit = 0;
        align = 0;
        case (req.format)
            FMT_R8: begin
                unit = 1;
                align = 4;
            end
            FMT_RGBA8, FMT_RGBA8_SRGB: begin
                unit = 4;
                align = 4;
            end
            FMT_BC1, FMT_BC1_SRGB, FMT_BC4: begin
                unit = 8;
                align = 8;
                blocked = 1'b1;
            end
            FMT_BC3, FMT_BC3_SRGB, FMT_BC5, FMT_BC7, FMT_BC7_SRGB: begin
                unit = 16;
                align = 16;
                blocked = 1'b1;
            end
            default: begin
                unit = 0;
            end
        endcase
        if (unit == 0) begin
            r.status = ST_BAD_FMT;
            expect_result(r);
            return;
        end
        running = 0;
        for (int unsigned lvl = 0; lvl < req.num_levels; lvl++) begin
            off = (lvl == 0) ? running : ((running + align - 1) / align) * align;
            size = blocked ? ((w + 3) / 4) * ((h + 3) / 4) * unit : w * h * unit;
            running = off + size;
            r.level       = lvl[3:0];
            r.lvl_width   = w[14:0];
            r.lvl_height  = h[14:0];
            r.lvl_offset  = sat31(off);
            r.lvl_bytes   = sat31(size);
            r.total_bytes = sat31(running);
            r.status      = ST_OK;
            r.last        = (lvl + 1 == req.num_levels);
            expect_result(r);
            w = (w / 2 == 0) ? 1 : w / 2;
            h = (h / 2 == 0) ? 1 : h / 2;
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_levels.size() == 0) begin
                $error("result transfer with nothing expected");
                failures++;
            end else begin
                want = pending_levels.pop_front();
                check_field("level", want.level, o_result.level);
                check_field("lvl_width", want.lvl_width, o_result.lvl_width);
                check_field("lvl_height", want.lvl_height, o_result.lvl_height);
                check_field("lvl_offset", want.lvl_offset, o_result.lvl_offset);
                check_field("lvl_bytes", want.lvl_bytes, o_result.lvl_bytes);
                check_field("total_bytes", want.total_bytes, o_result.total_bytes);
                check_field("status", want.status, o_result.status);
                check_field("last", want.last, o_result.last);
                if (want.status == ST_OK) levels_checked++;
                else errors_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("[texture_mip_chain_layout] ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_request(input t_req req, input logic typed, input t_result want);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        requests_sent++;
        if (typed) expect_result(want);
        else predict_layout(req);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned idle_plan [4];
        t_req req;
        idle_plan = '{0, 58, 0, 12};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            send_request(STIM_TABLE[k].req, STIM_TABLE[k].typed, STIM_TABLE[k].want);
        end
        wait_drained();

        foreach (idle_plan[p]) begin
            for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 80) begin
                    req.format = 4'($urandom_range(0, 10));
                    if ($urandom_range(0, 1) == 0) begin
                        req.width  = 15'($urandom_range(1, 64));
                        req.height = 15'($urandom_range(1, 64));
                    end else begin
                        req.width  = 15'($urandom_range(1, MAX_DIM));
                        req.height = 15'($urandom_range(1, MAX_DIM));
                    end
                    req.num_levels = 4'($urandom_range(1, chain_len(req.width, req.height)));
                end else begin
                    // noise: raw bits, mostly rejected
                    req = t_req'({$urandom, $urandom});
                end
                send_request(req, 1'b0, RES_NONE);
                if ($urandom_range(0, 99) < idle_plan[p]) sender_gap($urandom_range(1, 20));
                else if ($urandom_range(0, 59) == 0) wait_drained();
            end
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d requests, %0d level results and %0d error results checked",
                 requests_sent, levels_checked, errors_checked);
        $display("all formats and both reject kinds, sender idle 0/58/12 percent phases");
        if (failures == 0 && pending_levels.size() == 0) begin
            $display("[texture_mip_chain_layout] OK");
        end else begin
            $display("[texture_mip_chain_layout] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tmcl_pkg.sv
hdl/tmcl_size_unit.sv
hdl/texture_mip_chain_layout.sv
bench/texture_mip_chain_layout_tb.sv
